FILE: rtl/hmmap_pkg.sv
// Shared types and constants for the handheld memory map block.
package hmmap_pkg;

  localparam int ROM_BYTES_DEF  = 32768;
  localparam int DMA_LENGTH_DEF = 160;
  localparam int BOOT_BYTES     = 256;

  // stream widths, padded to whole bytes
  localparam int IN_W  = 32;
  localparam int OUT_W = 24;

  typedef struct packed {
    logic clear;     // clearing pass, one entry per cycle
    logic take;      // item accepted this cycle
    logic dma_step;  // one DMA copy cycle
    logic out_load;  // capture the result
  } hmmap_cmd_t;

  typedef struct packed {
    logic clear_last;  // last entry of the clearing pass
    logic item_dma;    // incoming item is a write to the DMA register
    logic dma_last;    // final DMA cycle
  } hmmap_stat_t;

endpackage

FILE: rtl/hmmap_dp.sv
// Datapath: address decode, the five stores, joypad and flag registers, DMA copy.
module hmmap_dp import hmmap_pkg::*; #(
  parameter int ROM_BYTES  = ROM_BYTES_DEF,
  parameter int DMA_LENGTH = DMA_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  hmmap_cmd_t       cmd,
  output hmmap_stat_t      stat,
  input  logic             cfg_wr,
  input  logic             cfg_bit,
  input  logic [IN_W-1:0]  s_tdata,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int ROM_AW     = $clog2(ROM_BYTES);
  localparam int VRAM_DEPTH = 8192;
  localparam int ERAM_DEPTH = 8192;
  localparam int HRAM_DEPTH = 16384;
  localparam int CLR_DEPTH  = (ROM_BYTES > HRAM_DEPTH) ? ROM_BYTES : HRAM_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam int DMA_CW     = $clog2(DMA_LENGTH + 1);

  localparam logic [2:0] MODE_READ      = 3'd0;
  localparam logic [2:0] MODE_WRITE     = 3'd1;
  localparam logic [2:0] MODE_LOAD_ROM  = 3'd2;
  localparam logic [2:0] MODE_LOAD_BOOT = 3'd3;
  localparam logic [2:0] MODE_SET_DIRTY = 3'd4;
  localparam logic [2:0] MODE_PRESS     = 3'd5;
  localparam logic [2:0] MODE_RELEASE   = 3'd6;

  localparam logic [2:0] SRC_BOOT = 3'd0;
  localparam logic [2:0] SRC_ROM  = 3'd1;
  localparam logic [2:0] SRC_ZERO = 3'd2;
  localparam logic [2:0] SRC_VRAM = 3'd3;
  localparam logic [2:0] SRC_ERAM = 3'd4;
  localparam logic [2:0] SRC_JOY  = 3'd5;
  localparam logic [2:0] SRC_HRAM = 3'd6;

  localparam logic [15:0] BOOT_TOP   = 16'h0100;
  localparam logic [15:0] ROM_TOP    = 16'h7FFF;
  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] ERAM_BASE  = 16'hA000;
  localparam logic [15:0] HRAM_BASE  = 16'hC000;
  localparam logic [15:0] JOY_ADDR   = 16'hFF00;
  localparam logic [15:0] IF_ADDR    = 16'hFF0F;
  localparam logic [15:0] LINE_ADDR  = 16'hFF44;
  localparam logic [15:0] DMA_ADDR   = 16'hFF46;
  localparam logic [15:0] LOCK_ADDR  = 16'hFF85;
  localparam logic [13:0] JOY_IDX    = 14'h3F00;
  localparam logic [13:0] IF_IDX     = 14'h3F0F;
  localparam logic [13:0] LOCK_IDX   = 14'h3F85;
  localparam logic [13:0] OAM_IDX    = 14'h3E00;
  localparam logic [7:0]  JOY_READ   = 8'h17;
  localparam logic [7:0]  JOY_RESET  = 8'hEF;
  localparam logic [7:0]  LOCK_RESET = 8'h01;
  localparam logic [7:0]  KEY_RESET  = 8'h0F;
  localparam logic [7:0]  IF_KEY_BIT = 8'h10;

  logic [2:0]  in_mode;
  logic [15:0] in_addr;
  logic [7:0]  in_data;
  logic [2:0]  in_key;

  assign in_mode = s_tdata[2:0];
  assign in_addr = s_tdata[18:3];
  assign in_data = s_tdata[26:19];
  assign in_key  = s_tdata[29:27];

  // stores
  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] boot_mem [BOOT_BYTES];
  logic [7:0] vram_mem [VRAM_DEPTH];
  logic [7:0] eram_mem [ERAM_DEPTH];
  logic [7:0] hram_mem [HRAM_DEPTH];

  // control-side state
  logic              overlay;
  logic              dirty, dirty_next;
  logic [7:0]        joy, joy_next;
  logic [7:0]        joy_sel, joy_sel_next;   // copy of byte 0xFF00
  logic [7:0]        if_flag, if_flag_next;   // copy of byte 0xFF0F
  logic [CLR_W-1:0]  clr_cnt;
  logic [DMA_CW-1:0] dma_cnt;

  // payload registers
  logic [7:0] page;
  logic [2:0] mode_q;
  logic       irq_q, irq_next;
  logic [7:0] out_rd, out_joy;
  logic       out_dirty, out_irq;

  // write ports
  logic              rom_we, boot_we, vram_we, eram_we, hram_we;
  logic [ROM_AW-1:0] rom_wa;
  logic [7:0]        boot_wa;
  logic [12:0]       vram_wa, eram_wa;
  logic [13:0]       hram_wa;
  logic [7:0]        rom_wd, vram_wd, eram_wd, hram_wd;

  // read side
  logic [15:0] rd_addr;
  logic [2:0]  sel, sel_q;
  logic [7:0]  rom_q, boot_q, vram_q, eram_q, hram_q, rd_byte;

  logic [7:0] key_mask, if_set;
  logic       was_up, want;

  assign key_mask = 8'b1 << in_key;
  assign was_up   = joy[in_key];
  assign want     = in_key[2] ? ~joy_sel[5] : ~joy_sel[4];
  assign if_set   = if_flag | IF_KEY_BIT;

  always_comb begin
    rom_we       = 1'b0;
    boot_we      = 1'b0;
    vram_we      = 1'b0;
    eram_we      = 1'b0;
    hram_we      = 1'b0;
    rom_wa       = in_addr[ROM_AW-1:0];
    boot_wa      = in_addr[7:0];
    vram_wa      = in_addr[12:0];
    eram_wa      = in_addr[12:0];
    hram_wa      = in_addr[13:0];
    rom_wd       = in_data;
    vram_wd      = in_data;
    eram_wd      = in_data;
    hram_wd      = in_data;
    dirty_next   = dirty;
    joy_next     = joy;
    joy_sel_next = joy_sel;
    if_flag_next = if_flag;
    irq_next     = 1'b0;
    if (cmd.clear) begin
      rom_we  = {1'b0, clr_cnt} < (CLR_W+1)'(ROM_BYTES);
      vram_we = {1'b0, clr_cnt} < (CLR_W+1)'(VRAM_DEPTH);
      eram_we = {1'b0, clr_cnt} < (CLR_W+1)'(ERAM_DEPTH);
      hram_we = {1'b0, clr_cnt} < (CLR_W+1)'(HRAM_DEPTH);
      rom_wa  = clr_cnt[ROM_AW-1:0];
      vram_wa = clr_cnt[12:0];
      eram_wa = clr_cnt[12:0];
      hram_wa = clr_cnt[13:0];
      rom_wd  = 8'h00;
      vram_wd = 8'h00;
      eram_wd = 8'h00;
      if (clr_cnt[13:0] == JOY_IDX) begin
        hram_wd = JOY_RESET;
      end else if (clr_cnt[13:0] == LOCK_IDX) begin
        hram_wd = LOCK_RESET;
      end else begin
        hram_wd = 8'h00;
      end
    end else if (cmd.dma_step) begin
      // each byte is written in the cycle after it is read
      hram_we = dma_cnt != '0;
      hram_wa = OAM_IDX | {6'd0, 8'(dma_cnt - DMA_CW'(1))};
      hram_wd = rd_byte;
    end else if (cmd.take) begin
      case (in_mode)
        MODE_READ: begin
        end
        MODE_WRITE: begin
          if (in_addr <= ROM_TOP) begin
          end else if (in_addr < ERAM_BASE) begin
            vram_we = 1'b1;
            if (in_data != 8'h00) dirty_next = 1'b1;
          end else if (in_addr < HRAM_BASE) begin
            eram_we = 1'b1;
          end else if (in_addr != LOCK_ADDR) begin
            hram_we = 1'b1;
            if (in_addr == LINE_ADDR) hram_wd = 8'h00;
            if (in_addr == JOY_ADDR) joy_sel_next = in_data;
            if (in_addr == IF_ADDR) if_flag_next = in_data;
          end
        end
        MODE_LOAD_ROM: begin
          rom_we = {1'b0, in_addr} < 17'(ROM_BYTES);
        end
        MODE_LOAD_BOOT: begin
          boot_we = in_addr < 16'(BOOT_BYTES);
        end
        MODE_SET_DIRTY: begin
          dirty_next = in_data[0];
        end
        MODE_PRESS: begin
          joy_next = joy & ~key_mask;
          if (want && was_up) begin
            hram_we      = 1'b1;
            hram_wa      = IF_IDX;
            hram_wd      = if_set;
            if_flag_next = if_set;
            irq_next     = 1'b1;
          end
        end
        MODE_RELEASE: begin
          joy_next = joy | key_mask;
        end
        default: begin
        end
      endcase
    end
  end

  // read decode
  assign rd_addr = cmd.dma_step ? {page, 8'(dma_cnt)} : in_addr;

  always_comb begin
    if (rd_addr < BOOT_TOP && overlay) begin
      sel = SRC_BOOT;
    end else if (rd_addr < VRAM_BASE) begin
      sel = ({1'b0, rd_addr} < 17'(ROM_BYTES)) ? SRC_ROM : SRC_ZERO;
    end else if (rd_addr < ERAM_BASE) begin
      sel = SRC_VRAM;
    end else if (rd_addr < HRAM_BASE) begin
      sel = SRC_ERAM;
    end else if (rd_addr == JOY_ADDR) begin
      sel = SRC_JOY;
    end else begin
      sel = SRC_HRAM;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) rom_mem[rom_wa] <= rom_wd;
    rom_q <= rom_mem[rd_addr[ROM_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (boot_we) boot_mem[boot_wa] <= in_data;
    boot_q <= boot_mem[rd_addr[7:0]];
  end

  always_ff @(posedge clk) begin
    if (vram_we) vram_mem[vram_wa] <= vram_wd;
    vram_q <= vram_mem[rd_addr[12:0]];
  end

  always_ff @(posedge clk) begin
    if (eram_we) eram_mem[eram_wa] <= eram_wd;
    eram_q <= eram_mem[rd_addr[12:0]];
  end

  always_ff @(posedge clk) begin
    if (hram_we) hram_mem[hram_wa] <= hram_wd;
    hram_q <= hram_mem[rd_addr[13:0]];
  end

  always_ff @(posedge clk) begin
    sel_q <= sel;
  end

  always_comb begin
    case (sel_q)
      SRC_BOOT: rd_byte = boot_q;
      SRC_ROM:  rd_byte = rom_q;
      SRC_VRAM: rd_byte = vram_q;
      SRC_ERAM: rd_byte = eram_q;
      SRC_JOY:  rd_byte = JOY_READ;
      SRC_HRAM: rd_byte = hram_q;
      default:  rd_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay <= 1'b1;
      dirty   <= 1'b0;
      joy     <= KEY_RESET;
      joy_sel <= JOY_RESET;
      if_flag <= 8'h00;
      clr_cnt <= '0;
      dma_cnt <= '0;
    end else begin
      if (cfg_wr) overlay <= cfg_bit;
      dirty   <= dirty_next;
      joy     <= joy_next;
      joy_sel <= joy_sel_next;
      if_flag <= if_flag_next;
      if (cmd.clear) clr_cnt <= clr_cnt + CLR_W'(1);
      if (cmd.take) begin
        dma_cnt <= '0;
      end else if (cmd.dma_step) begin
        dma_cnt <= dma_cnt + DMA_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode_q <= in_mode;
      irq_q  <= irq_next;
      page   <= in_data;
    end
    if (cmd.out_load) begin
      out_rd    <= (mode_q == MODE_READ) ? rd_byte : 8'h00;
      out_dirty <= dirty;
      out_joy   <= joy;
      out_irq   <= irq_q;
    end
  end

  assign stat.clear_last = clr_cnt == CLR_W'(CLR_DEPTH - 1);
  assign stat.item_dma   = (in_mode == MODE_WRITE) && (in_addr == DMA_ADDR);
  assign stat.dma_last   = dma_cnt == DMA_CW'(DMA_LENGTH);

  assign m_tdata = {6'd0, out_irq, out_joy, out_dirty, out_rd};

endmodule

FILE: rtl/hmmap_ctrl.sv
// Controller: clearing pass, item sequencing, DMA loop and output handshake.
module hmmap_ctrl import hmmap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  hmmap_stat_t stat,
  output hmmap_cmd_t  cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_DMA    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state, state_next;

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.take = s_tvalid && s_tready;
        if (cmd.take) state_next = stat.item_dma ? ST_DMA : ST_FINISH;
      end
      ST_DMA: begin
        cmd.dma_step = 1'b1;
        if (stat.dma_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.out_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_take_moves_on: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == ST_FINISH || state == ST_DMA))
    else $error("accepted item did not start its work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !m_tvalid)
    else $error("result loaded over a pending one");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> m_tvalid)
    else $error("finished item did not present its result");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && !m_tvalid))
    else $error("traffic during clearing pass");
`endif

endmodule

FILE: rtl/handheld_memory_map_with_dma_top.sv
// Top level of the handheld memory map with object-attribute DMA.
// Flow: an item is accepted, then its result is captured from registered store
//   data into the output register; a write to 0xFF46 runs the DMA copy loop in
//   between, one copy byte per cycle with read and write overlapped.
// A new item is taken only once the previous result is captured and the output
//   is free; a DMA item holds the block for its whole copy loop.
// Reset (rst, synchronous, active high) clears control state and then runs a
//   clearing pass over max(ROM_BYTES, 16384) entries that zeroes ROM, video, external
//   and high RAM (loading 0xEF at 0xFF00 and 0x01 at 0xFF85); no item is taken
//   meanwhile. The boot store is not cleared. Config writes are always taken.
module handheld_memory_map_with_dma_top import hmmap_pkg::*; #(
  parameter int ROM_BYTES  = ROM_BYTES_DEF,
  parameter int DMA_LENGTH = DMA_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // config: boot_overlay_enable
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  // input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata: mode[2:0], address[18:3], write_data[26:19], key[29:27], zero pad
  input  logic [IN_W-1:0]  s_tdata,
  // output stream
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata: read_data[7:0], vram_dirty[8], joypad_bits[16:9],
  //          interrupt_raised[17], zero pad
  output logic [OUT_W-1:0] m_tdata
);

  hmmap_cmd_t  cmd;
  hmmap_stat_t stat;

  // the overlay register can take a write in any cycle
  assign cfg_ready = 1'b1;

  hmmap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hmmap_dp #(
    .ROM_BYTES  (ROM_BYTES),
    .DMA_LENGTH (DMA_LENGTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .cfg_wr  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

FILE: dv/handheld_memory_map_with_dma_top_tb.sv
// Self-checking stream testbench for the handheld memory map with object-attribute DMA.
`timescale 1ns / 1ps

module handheld_memory_map_with_dma_top_tb import hmmap_pkg::*;;

  // Bus operations carried in the low three bits of s_tdata
  typedef enum logic [2:0] {
    OP_READ        = 3'd0,
    OP_WRITE       = 3'd1,
    OP_LOAD_ROM    = 3'd2,
    OP_LOAD_BOOT   = 3'd3,
    OP_SET_DIRTY   = 3'd4,
    OP_KEY_PRESS   = 3'd5,
    OP_KEY_RELEASE = 3'd6,
    OP_SPARE       = 3'd7
  } op_e;

  // Result layout, MSB first so it lines up with m_tdata[17:0]
  typedef struct packed {
    logic       irq;
    logic [7:0] joypad_bits;
    logic       vram_dirty;
    logic [7:0] read_data;
  } result_t;

  // Fixed addresses of the memory map
  localparam logic [15:0] ROM_TOP    = 16'h7FFF;
  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] XRAM_BASE  = 16'hA000;
  localparam logic [15:0] HRAM_BASE  = 16'hC000;
  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [15:0] JOYP_ADDR  = 16'hFF00;
  localparam logic [15:0] IF_ADDR    = 16'hFF0F;
  localparam logic [15:0] LY_ADDR    = 16'hFF44;
  localparam logic [15:0] DMA_ADDR   = 16'hFF46;
  localparam logic [15:0] LOCK_ADDR  = 16'hFF85;
  localparam logic [7:0]  JOYP_READ  = 8'h17;
  localparam logic [7:0]  IF_JOYPAD  = 8'h10;

  localparam int IDLE_PCT     = 30;     // chance of a bubble on either side
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int SETTLE       = DMA_LENGTH_DEF + 8;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int RAND_PHASES  = 5;
  localparam int PHASE_ITEMS  = 40;
  localparam int MAX_PRINTS   = 30;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;   // mode, address, write_data, key, zero pad
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;        // read_data, vram_dirty, joypad_bits, irq, pad

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  handheld_memory_map_with_dma_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the memory map, updated at each accepted transaction
  // ---------------------------------------------------------------------------
  logic [7:0] boot_mem [0:BOOT_BYTES-1];
  logic [7:0] rom_mem  [0:ROM_BYTES_DEF-1];
  logic [7:0] vram_mem [0:8191];
  logic [7:0] xram_mem [0:8191];
  logic [7:0] hram_mem [0:16383];
  logic       dirty_flag;
  logic [7:0] joypad;
  logic       overlay_en;

  result_t     pending_results [$];   // expected results, oldest first
  logic [15:0] recent_addrs [$];      // addresses touched lately, reused for reads

  int err_count    = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int dma_count    = 0;
  int irq_count    = 0;
  int cfg_writes   = 0;

  // Side-band controls for the stall generators
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_req     = 1'b0;

  task automatic map_reset();
    foreach (rom_mem[i])  rom_mem[i]  = 8'h00;
    foreach (vram_mem[i]) vram_mem[i] = 8'h00;
    foreach (xram_mem[i]) xram_mem[i] = 8'h00;
    foreach (hram_mem[i]) hram_mem[i] = 8'h00;
    hram_mem[JOYP_ADDR[13:0]] = 8'hEF;
    hram_mem[LOCK_ADDR[13:0]] = 8'h01;
    dirty_flag = 1'b0;
    joypad     = 8'h0F;
    overlay_en = 1'b1;
  endtask

  // Read decode; the bases are aligned so the low bits index each store
  function automatic logic [7:0] map_read(logic [15:0] a);
    if (a < 16'h0100 && overlay_en) return boot_mem[a[7:0]];
    if (a < VRAM_BASE)              return rom_mem[a[14:0]];
    if (a < XRAM_BASE)              return vram_mem[a[12:0]];
    if (a < HRAM_BASE)              return xram_mem[a[12:0]];
    if (a == JOYP_ADDR)             return JOYP_READ;
    return hram_mem[a[13:0]];
  endfunction

  function automatic void map_write(logic [15:0] a, logic [7:0] v);
    logic [15:0] src;
    if (a <= ROM_TOP) return;
    if (a < XRAM_BASE) begin
      vram_mem[a[12:0]] = v;
      if (v != 8'h00) dirty_flag = 1'b1;
      return;
    end
    if (a < HRAM_BASE) begin
      xram_mem[a[12:0]] = v;
      return;
    end
    if (a == LOCK_ADDR) return;
    if (a == LY_ADDR) begin
      hram_mem[a[13:0]] = 8'h00;
      return;
    end
    if (a == DMA_ADDR) begin
      // page register first, then the ascending copy through the read decode
      hram_mem[a[13:0]] = v;
      src = {v, 8'h00};
      for (int i = 0; i < DMA_LENGTH_DEF; i++) begin
        hram_mem[(OAM_BASE + 16'(i)) & 16'h3FFF] = map_read(src + 16'(i));
      end
      dma_count++;
      return;
    end
    hram_mem[a[13:0]] = v;
  endfunction

  // Applies one transaction to the shadow map and returns its result
  function automatic result_t map_apply(op_e op, logic [15:0] a, logic [7:0] d,
                                        logic [2:0] k);
    result_t    r;
    logic [7:0] mask;
    logic [7:0] sel;
    logic       enabled;
    r    = '0;
    mask = 8'h01 << k;
    case (op)
      OP_READ:      r.read_data = map_read(a);
      OP_WRITE:     map_write(a, d);
      OP_LOAD_ROM:  if (a < ROM_BYTES_DEF) rom_mem[a[14:0]] = d;
      OP_LOAD_BOOT: if (a < BOOT_BYTES) boot_mem[a[7:0]] = d;
      OP_SET_DIRTY: dirty_flag = d[0];
      OP_KEY_PRESS: begin
        // select bits live in the stored joypad byte, not the 0x17 read value
        sel     = hram_mem[JOYP_ADDR[13:0]];
        enabled = (k > 3'd3) ? !sel[5] : !sel[4];
        if (enabled && (joypad & mask) != 8'h00) begin
          map_write(IF_ADDR, map_read(IF_ADDR) | IF_JOYPAD);
          r.irq = 1'b1;
          irq_count++;
        end
        joypad = joypad & ~mask;
      end
      OP_KEY_RELEASE: joypad = joypad | mask;
      default: ;
    endcase
    r.vram_dirty  = dirty_flag;
    r.joypad_bits = joypad;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the result checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    err_count++;
    // keep the log short on a badly broken build; every mismatch still counts
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h",
                                results_seen, name, got, want));
  endtask

  // Outputs are sampled at the edge, before any NBA of that edge lands
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[17:0];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", got));
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", got.read_data, want.read_data);
        check_field("vram_dirty", 8'(got.vram_dirty), 8'(want.vram_dirty));
        check_field("joypad_bits", got.joypad_bits, want.joypad_bits);
        check_field("interrupt_raised", 8'(got.irq), 8'(want.irq));
        results_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random bubbles, or a long hold-off counted here when requested
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (!sink_idle_on) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Drives one transaction and predicts its result once it is taken. tvalid is
  // left high so the next call can follow back to back without a bubble.
  task automatic send_item(op_e op, logic [15:0] a, logic [7:0] d, logic [2:0] k);
    if (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, k, d, a, op};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(map_apply(op, a, d, k));
    items_sent++;
    if (op == OP_WRITE || op == OP_LOAD_ROM || op == OP_LOAD_BOOT) begin
      recent_addrs.push_back(a);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
    end
  endtask

  // Stops offering, waits for every pending result, then lets the SETTLE period,
  // sized from DMA_LENGTH_DEF, pass. Always advances time, so a following send never
  // collides with the tvalid drop made here.
  task automatic drain();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; only called with the block drained
  task automatic write_overlay(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    overlay_en = v;
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(19))
      0, 1, 2, 3: return 8'h00;
      4:          return 8'hFF;
      default:    return 8'($urandom);
    endcase
  endfunction

  // Address spread over every region, with the odd registers and recently
  // written locations weighted up so reads land on live data
  function automatic logic [15:0] pick_addr();
    logic [15:0] specials [15];
    specials = '{JOYP_ADDR, IF_ADDR, LY_ADDR, DMA_ADDR, LOCK_ADDR, 16'hFFFF,
                 ROM_TOP, VRAM_BASE, 16'h9FFF, XRAM_BASE, 16'hBFFF, HRAM_BASE,
                 16'h0000, 16'h00FF, 16'h0100};
    case ($urandom_range(9))
      0:       return 16'($urandom_range(0, 16'h01FF));
      1:       return 16'($urandom_range(0, ROM_TOP));
      2:       return 16'($urandom_range(VRAM_BASE, 16'h9FFF));
      3:       return 16'($urandom_range(XRAM_BASE, 16'hBFFF));
      4:       return 16'($urandom_range(HRAM_BASE, 16'hFDFF));
      5:       return 16'($urandom_range(OAM_BASE, 16'hFE9F));
      6:       return specials[$urandom_range(14)];
      7, 8: begin
        if (recent_addrs.size() != 0)
          return recent_addrs[$urandom_range(recent_addrs.size() - 1)];
        return 16'($urandom);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_page();
    case ($urandom_range(8))
      0: return 8'h00;   // boot or ROM, depending on the overlay
      1: return 8'h01;
      2: return 8'h80;   // video RAM
      3: return 8'hA0;   // external RAM
      4: return 8'hC0;
      5: return 8'hFE;   // copy onto itself
      6: return 8'hFF;   // covers the joypad and DMA registers
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every boot entry gets loaded first, so no read ever touches an unloaded one
  task automatic test_boot_fill();
    for (int i = 0; i < BOOT_BYTES; i++) send_item(OP_LOAD_BOOT, 16'(i), 8'($urandom), 3'd0);
    send_item(OP_LOAD_BOOT, 16'h0100, 8'h77, 3'd0);   // out of range, dropped
    send_item(OP_LOAD_BOOT, 16'hFFFF, 8'h88, 3'd0);
    send_item(OP_READ, 16'h0000, 8'h00, 3'd0);
    send_item(OP_READ, 16'h00FF, 8'h00, 3'd0);
  endtask

  task automatic test_special_cases();
    send_item(OP_READ, JOYP_ADDR, 8'h00, 3'd0);       // always 0x17
    send_item(OP_WRITE, LOCK_ADDR, 8'h55, 3'd0);      // locked byte keeps 0x01
    send_item(OP_READ, LOCK_ADDR, 8'h00, 3'd0);
    send_item(OP_WRITE, ROM_TOP, 8'hAA, 3'd0);        // ROM area is read-only
    send_item(OP_READ, ROM_TOP, 8'h00, 3'd0);
    send_item(OP_LOAD_ROM, ROM_TOP, 8'hC3, 3'd0);
    send_item(OP_LOAD_ROM, 16'h8000, 8'h99, 3'd0);    // beyond ROM, dropped
    send_item(OP_READ, ROM_TOP, 8'h00, 3'd0);
    send_item(OP_WRITE, LY_ADDR, 8'hAB, 3'd0);        // line counter forced to 0
    send_item(OP_READ, LY_ADDR, 8'h00, 3'd0);
    send_item(OP_WRITE, VRAM_BASE, 8'h00, 3'd0);      // zero byte: no dirty
    send_item(OP_WRITE, 16'h9FFF, 8'h5A, 3'd0);       // nonzero: dirty
    send_item(OP_SET_DIRTY, 16'h0000, 8'hFE, 3'd0);   // bit 0 clears it
    send_item(OP_WRITE, 16'hBFFF, 8'h3C, 3'd0);
    send_item(OP_WRITE, 16'hC010, 8'h81, 3'd0);
    send_item(OP_WRITE, DMA_ADDR, 8'hC0, 3'd0);       // copy page 0xC0 to OAM
    send_item(OP_READ, 16'hFE10, 8'h00, 3'd0);
    send_item(OP_KEY_PRESS, 16'h0000, 8'h00, 3'd0);   // d-pad selected: irq
    send_item(OP_KEY_PRESS, 16'h0000, 8'h00, 3'd0);   // already held: none
    send_item(OP_KEY_PRESS, 16'h0000, 8'h00, 3'd7);   // buttons deselected
    send_item(OP_WRITE, JOYP_ADDR, 8'h10, 3'd0);      // select buttons only
    send_item(OP_KEY_PRESS, 16'h0000, 8'h00, 3'd6);
    send_item(OP_KEY_PRESS, 16'h0000, 8'h00, 3'd2);
    send_item(OP_READ, IF_ADDR, 8'h00, 3'd0);
    send_item(OP_SPARE, 16'hFFFF, 8'hFF, 3'd7);       // unused op, no effect
  endtask

  // Low page decode with the overlay off and back on, by read and by DMA
  task automatic test_overlay();
    drain();
    write_overlay(1'b0);
    send_item(OP_LOAD_ROM, 16'h0005, 8'h66, 3'd0);
    send_item(OP_READ, 16'h0005, 8'h00, 3'd0);
    send_item(OP_WRITE, DMA_ADDR, 8'h00, 3'd0);
    send_item(OP_READ, 16'hFE05, 8'h00, 3'd0);
    drain();
    write_overlay(1'b1);
    send_item(OP_READ, 16'h0005, 8'h00, 3'd0);
    send_item(OP_WRITE, DMA_ADDR, 8'h00, 3'd0);
    send_item(OP_READ, 16'hFE05, 8'h00, 3'd0);
  endtask

  // Receiver stalls for a long stretch while items keep coming; the block
  // has to back up into its input
  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_item(OP_READ, pick_addr(), 8'h00, 3'($urandom));
  endtask

  task automatic send_random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 28)
      send_item(OP_READ, pick_addr(), 8'($urandom), 3'($urandom));
    else if (roll < 50)
      send_item(OP_WRITE, pick_addr(), pick_byte(), 3'($urandom));
    else if (roll < 58)
      send_item(OP_LOAD_ROM, ($urandom_range(9) == 0) ? 16'($urandom)
                : 16'($urandom_range(0, 16'h01FF)), pick_byte(), 3'($urandom));
    else if (roll < 61)
      send_item(OP_LOAD_BOOT, ($urandom_range(7) == 0) ? 16'($urandom)
                : 16'($urandom_range(0, 255)), 8'($urandom), 3'($urandom));
    else if (roll < 64)
      send_item(OP_SET_DIRTY, 16'($urandom), 8'($urandom), 3'($urandom));
    else if (roll < 77)
      send_item(OP_KEY_PRESS, 16'($urandom), 8'($urandom), 3'($urandom));
    else if (roll < 88)
      send_item(OP_KEY_RELEASE, 16'($urandom), 8'($urandom), 3'($urandom));
    else if (roll < 94)
      send_item(OP_WRITE, DMA_ADDR, pick_page(), 3'($urandom));
    else if (roll < 96)
      send_item(OP_SPARE, 16'($urandom), 8'($urandom), 3'($urandom));
    else
      send_item(OP_WRITE, JOYP_ADDR, 8'($urandom), 3'($urandom));   // key select
  endtask

  // Phases with the overlay changed in between; the second phase runs with
  // no bubbles on either side
  task automatic test_random();
    logic [0:RAND_PHASES-1] overlay_plan;
    overlay_plan = {1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom)};
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      write_overlay(overlay_plan[p]);
      src_idle_on  = (p != 1);
      sink_idle_on = (p != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    map_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // the block clears its stores after reset; s_tready stays low until done
    write_overlay(1'b1);
    test_boot_fill();
    test_special_cases();
    test_overlay();
    test_backpressure();
    test_random();
    drain();
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results still pending", pending_results.size()));
    $display("Covered %0d transactions, %0d results, %0d DMA copies, %0d key interrupts,",
             items_sent, results_seen, dma_count, irq_count);
    $display("%0d overlay writes, a %0d-cycle receiver hold-off; %0d mismatches.",
             cfg_writes, HOLD_CYCLES, err_count);
    if (err_count == 0) begin
      $display("handheld_memory_map_with_dma_top verification clean");
    end else begin
      $display("handheld_memory_map_with_dma_top verification failed");
    end
    $finish;
  end

  // Watchdog: covers the clearing pass and every item at its slowest
  initial begin
    #10ms;
    $display("handheld_memory_map_with_dma_top verification failed");
    $finish;
  end

endmodule
